### sv/jsu_pkg.sv
// Shared types, character codes and sizes of the JSON string unescape decoder.
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_SLASH     = 8'h2f;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_N         = 8'h6e;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_TEXT = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_EOD    = 2'd2,
    KIND_BADHEX = 2'd3
  } kind_e;

  typedef enum logic {
    OP_SINGLE = 1'b0,
    OP_UTF8   = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [15:0] data;
  } cmd_t;

endpackage

### sv/jsu_if.sv
// Handshake interfaces for the input byte channel and the decoded result channel.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_data;

  modport source (output valid, output text_byte, output end_of_data, input ready);
  modport sink (input valid, input text_byte, input end_of_data, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

### sv/jsu_front.sv
// Front end: accepts input bytes, tracks the string state and issues result commands.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsu_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [15:0] cp_next;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      CHAR_QUOTE:     r = {1'b1, CHAR_QUOTE};
      CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
      CHAR_SLASH:     r = {1'b1, CHAR_SLASH};
      CHAR_B:         r = {1'b1, 8'h08};
      CHAR_F:         r = {1'b1, 8'h0c};
      CHAR_N:         r = {1'b1, 8'h0a};
      CHAR_R:         r = {1'b1, 8'h0d};
      CHAR_T:         r = {1'b1, 8'h09};
      default:        r = 9'd0;
    endcase
    return r;
  endfunction

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign {hex_ok, hex_digit} = hex_decode(in_i.text_byte);
  assign {esc_ok, esc_byte}  = esc_decode(in_i.text_byte);
  assign cp_next = {cp_q[11:0], hex_digit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      hex_cnt_q <= 2'd0;
      cp_q      <= 16'd0;
    end else begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    push_o    = 1'b0;
    cmd_o     = '{op: OP_SINGLE, kind: KIND_DATA, data: 16'd0};
    if (accept) begin
      unique case (mode_q)
        MODE_TEXT: begin
          if (in_i.end_of_data) begin
            mode_d     = MODE_IDLE;
            hex_cnt_d  = 2'd0;
            cp_d       = 16'd0;
            push_o     = 1'b1;
            cmd_o.kind = KIND_EOD;
          end else if (in_i.text_byte == CHAR_QUOTE) begin
            mode_d     = MODE_IDLE;
            hex_cnt_d  = 2'd0;
            cp_d       = 16'd0;
            push_o     = 1'b1;
            cmd_o.kind = KIND_DONE;
          end else if (in_i.text_byte == CHAR_BACKSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            push_o     = 1'b1;
            cmd_o.data = {8'd0, in_i.text_byte};
          end
        end
        MODE_ESC: begin
          if (in_i.end_of_data) begin
            mode_d     = MODE_IDLE;
            hex_cnt_d  = 2'd0;
            cp_d       = 16'd0;
            push_o     = 1'b1;
            cmd_o.kind = KIND_EOD;
          end else if (in_i.text_byte == CHAR_U) begin
            mode_d    = MODE_HEX;
            hex_cnt_d = 2'd0;
            cp_d      = 16'd0;
          end else begin
            mode_d     = MODE_TEXT;
            push_o     = esc_ok;
            cmd_o.data = {8'd0, esc_byte};
          end
        end
        MODE_HEX: begin
          if (in_i.end_of_data || !hex_ok) begin
            mode_d     = MODE_IDLE;
            hex_cnt_d  = 2'd0;
            cp_d       = 16'd0;
            push_o     = 1'b1;
            cmd_o.kind = in_i.end_of_data ? KIND_EOD : KIND_BADHEX;
          end else if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
            cp_d      = cp_next;
          end else begin
            mode_d     = MODE_TEXT;
            hex_cnt_d  = 2'd0;
            cp_d       = 16'd0;
            push_o     = 1'b1;
            cmd_o.op   = OP_UTF8;
            cmd_o.data = cp_next;
          end
        end
        default: begin
          if (!in_i.end_of_data) begin
            mode_d    = MODE_TEXT;
            hex_cnt_d = 2'd0;
            cp_d      = 16'd0;
          end
        end
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("command issued while the queue is full");
  a_hex_count_only_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_HEX) |-> (hex_cnt_q == 2'd0))
    else $error("hex digit count is nonzero outside a unicode escape");
  a_end_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.kind != KIND_DATA) |=> (mode_q == MODE_IDLE))
    else $error("string end did not return to idle");

endmodule

### sv/jsu_fifo.sv
// Short command queue that decouples the front end from the result expander.
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output jsu_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

endmodule

### sv/jsu_back.sv
// Back end: expands queued commands into result transactions behind an output register.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  jsu_pkg::cmd_t cmd_i,
  output logic          pop_o,
  jsu_out_if.source     out_o
);
  import jsu_pkg::*;

  logic [1:0]  step_q, step_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  kind_e       kind_q;
  logic        last_q;
  logic        load;
  logic [1:0]  last_step;
  logic [7:0]  byte_sel;
  logic [15:0] v;

  assign v    = cmd_i.data;
  assign load = valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    last_step = 2'd0;
    byte_sel  = v[7:0];
    if (cmd_i.op == OP_UTF8) begin
      if (v != 16'd0 && v < UTF8_ONE_LIMIT) begin
        last_step = 2'd0;
        byte_sel  = v[7:0];
      end else if (v < UTF8_TWO_LIMIT) begin
        last_step = 2'd1;
        byte_sel  = (step_q == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
      end else begin
        last_step = 2'd2;
        unique case (step_q)
          2'd0:    byte_sel = {4'b1110, v[15:12]};
          2'd1:    byte_sel = {2'b10, v[11:6]};
          default: byte_sel = {2'b10, v[5:0]};
        endcase
      end
    end
  end

  assign pop_o  = load && (step_q == last_step);
  assign step_d = pop_o ? 2'd0 : (load ? step_q + 2'd1 : step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      kind_q     <= cmd_i.kind;
      last_q     <= (step_q == last_step);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.kind     = kind_q;
  assign out_o.last     = last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 2'd3)
    else $error("expander step out of range");
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_DATA) |-> last_q)
    else $error("status result not marked last");
  a_step_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 2'd0) |-> (valid_i && cmd_i.op == OP_UTF8))
    else $error("expansion in progress without a unicode command at the head");

endmodule

### sv/json_string_unescape_decoder.sv
// Top level of the JSON string unescape decoder.
//
//   Channel  Direction  Payload                     Transfer
//   in_i     in         text_byte, end_of_data      valid && ready
//   out_o    out        out_byte, kind, last        valid && ready
//
// One input transaction per cycle is accepted while the command queue has room.
// A result passes through the command queue and then the output register before it is
// presented.
// A unicode escape yields up to three results, which the expander emits one byte per
// cycle while the output is not stalled.
// Reset is asynchronous and active low and returns the decoder to idle.
// Output stalls fill the queue of QueueDepth commands before input is held off.
module json_string_unescape_decoder #(
  parameter int unsigned QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  logic push;
  logic full;
  logic head_valid;
  logic pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### sim/json_string_unescape_decoder_test.sv
// Self-checking testbench for the JSON string unescape decoder with a built-in decoding predictor.
module json_string_unescape_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CTRL_BACKSPACE = 8'h08;
  localparam logic [7:0] CTRL_FORM_FEED = 8'h0c;
  localparam logic [7:0] CTRL_NEW_LINE  = 8'h0a;
  localparam logic [7:0] CTRL_RETURN    = 8'h0d;
  localparam logic [7:0] CTRL_TAB       = 8'h09;
  localparam logic [2:0] UTF8_LEAD_TWO   = 3'b110;
  localparam logic [3:0] UTF8_LEAD_THREE = 4'b1110;
  localparam logic [1:0] UTF8_CONTINUE   = 2'b10;
  localparam int unsigned IDLE_PERCENT   = 17;
  localparam int unsigned RANDOM_ITEMS   = 185;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #10 clk_i = ~clk_i;

  mode_e       dec_mode       = MODE_IDLE;
  logic [1:0]  dec_hex_count  = '0;
  logic [15:0] dec_code_point = '0;
  decoded_t    decoded_q[$];

  int unsigned in_count     = 0;
  int unsigned out_count    = 0;
  int unsigned data_count   = 0;
  int unsigned closed_count = 0;
  int unsigned abort_count  = 0;
  int unsigned error_count  = 0;
  bit          sender_idles   = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned hold_request   = 0;

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return {1'b1, 4'(c - CHAR_ZERO)};
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return {1'b1, 4'(c - CHAR_LOWER_A + 10)};
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return {1'b1, 4'(c - CHAR_UPPER_A + 10)};
    return 5'b0;
  endfunction

  function automatic decoded_t data_byte(logic [7:0] b);
    decoded_t r;
    r.out_byte = b;
    r.kind = KIND_DATA;
    r.last = 1'b0;
    return r;
  endfunction

  // Advances the decoder state by one input byte and queues the bytes it should emit.
  function automatic void decode_input(logic [7:0] c, logic eod);
    decoded_t   batch[$];
    decoded_t   closing;
    logic [4:0] digit;
    logic       ends;
    kind_e      end_kind;
    ends = 1'b0;
    end_kind = KIND_DONE;
    case (dec_mode)
      MODE_TEXT: begin
        if (eod) begin
          ends = 1'b1;
          end_kind = KIND_EOD;
        end else if (c == CHAR_QUOTE) begin
          ends = 1'b1;
          end_kind = KIND_DONE;
        end else if (c == CHAR_BACKSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          batch = {batch, data_byte(c)};
        end
      end
      MODE_ESC: begin
        if (eod) begin
          ends = 1'b1;
          end_kind = KIND_EOD;
        end else begin
          dec_mode = MODE_TEXT;
          case (c)
            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: batch = {batch, data_byte(c)};
            CHAR_B: batch = {batch, data_byte(CTRL_BACKSPACE)};
            CHAR_F: batch = {batch, data_byte(CTRL_FORM_FEED)};
            CHAR_N: batch = {batch, data_byte(CTRL_NEW_LINE)};
            CHAR_R: batch = {batch, data_byte(CTRL_RETURN)};
            CHAR_T: batch = {batch, data_byte(CTRL_TAB)};
            CHAR_U: begin
              dec_mode = MODE_HEX;
              dec_hex_count = '0;
              dec_code_point = '0;
            end
            default: ;
          endcase
        end
      end
      MODE_HEX: begin
        digit = hex_digit(c);
        if (eod) begin
          ends = 1'b1;
          end_kind = KIND_EOD;
        end else if (!digit[4]) begin
          ends = 1'b1;
          end_kind = KIND_BADHEX;
        end else begin
          dec_code_point = {dec_code_point[11:0], digit[3:0]};
          if (dec_hex_count < 2'd3) begin
            dec_hex_count++;
          end else begin
            dec_hex_count = '0;
            dec_mode = MODE_TEXT;
            if (dec_code_point != '0 && dec_code_point < UTF8_ONE_LIMIT) begin
              batch = {batch, data_byte(dec_code_point[7:0])};
            end else if (dec_code_point < UTF8_TWO_LIMIT) begin
              batch = {batch, data_byte({UTF8_LEAD_TWO, dec_code_point[10:6]})};
              batch = {batch, data_byte({UTF8_CONTINUE, dec_code_point[5:0]})};
            end else begin
              batch = {batch, data_byte({UTF8_LEAD_THREE, dec_code_point[15:12]})};
              batch = {batch, data_byte({UTF8_CONTINUE, dec_code_point[11:6]})};
              batch = {batch, data_byte({UTF8_CONTINUE, dec_code_point[5:0]})};
            end
            dec_code_point = '0;
          end
        end
      end
      default: begin
        dec_mode = eod ? MODE_IDLE : MODE_TEXT;
        dec_hex_count = '0;
        dec_code_point = '0;
      end
    endcase
    if (ends) begin
      dec_mode = MODE_IDLE;
      dec_hex_count = '0;
      dec_code_point = '0;
      closing.out_byte = 8'h00;
      closing.kind = end_kind;
      closing.last = 1'b0;
      batch = {batch, closing};
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    decoded_q = {decoded_q, batch};
  endfunction

  function automatic void check_decoded(logic [7:0] out_byte, logic [1:0] kind, logic last);
    decoded_t want;
    if (decoded_q.size() == 0) begin
      $display("%t unexpected result: byte %h kind %0d last %b", $time, out_byte, kind, last);
      error_count++;
      return;
    end
    want = decoded_q.pop_front();
    if (out_byte !== want.out_byte) begin
      $display("%t out_byte mismatch: expected %h, actual %h", $time, want.out_byte, out_byte);
      error_count++;
    end
    if (kind !== want.kind) begin
      $display("%t kind mismatch: expected %0d, actual %0d", $time, want.kind, kind);
      error_count++;
    end
    if (last !== want.last) begin
      $display("%t last mismatch: expected %b, actual %b", $time, want.last, last);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        in_count++;
        decode_input(in_ch.text_byte, in_ch.end_of_data);
      end
      if (out_ch.valid && out_ch.ready) begin
        out_count++;
        case (out_ch.kind)
          KIND_DATA: data_count++;
          KIND_DONE: closed_count++;
          default:   abort_count++;
        endcase
        check_decoded(out_ch.out_byte, out_ch.kind, out_ch.last);
      end
    end
  end

  // The receiver counts its own long hold-off so the input side keeps offering meanwhile.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 99) < IDLE_PERCENT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_text(logic [7:0] b, logic eod);
    int unsigned gap;
    gap = 0;
    if (sender_idles) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_of_data <= eod;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nibble);
    if (nibble < 10) return CHAR_ZERO + nibble;
    if ($urandom_range(0, 1)) return 8'(CHAR_UPPER_A + nibble - 10);
    return 8'(CHAR_LOWER_A + nibble - 10);
  endfunction

  task automatic send_unicode(logic [15:0] code_point, int unsigned digits);
    send_text(CHAR_BACKSLASH, 1'b0);
    send_text(CHAR_U, 1'b0);
    for (int i = 0; i < digits; i++) send_text(hex_char(code_point[15 - 4 * i -: 4]), 1'b0);
  endtask

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) != 5'b0);
    return c;
  endfunction

  function automatic logic [7:0] escape_letter(int unsigned idx);
    case (idx)
      0: return CHAR_QUOTE;
      1: return CHAR_BACKSLASH;
      2: return CHAR_SLASH;
      3: return CHAR_B;
      4: return CHAR_F;
      5: return CHAR_N;
      6: return CHAR_R;
      default: return CHAR_T;
    endcase
  endfunction

  function automatic logic [15:0] random_code_point();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
      1: return 16'($urandom_range(1, 16'h007f));
      2: return 16'($urandom_range(16'h0080, 16'h07ff));
      3: return 16'($urandom_range(16'hd800, 16'hdfff));
      default: return 16'($urandom_range(16'h0800, 16'hffff));
    endcase
  endfunction

  task automatic wait_drained();
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic test_framing();
    send_text(8'($urandom_range(0, 255)), 1'b1);
    send_text(8'hff, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hff, 1'b0);
    send_text(CHAR_BACKSLASH, 1'b0);
    send_text(CHAR_X, 1'b0);
    send_text(CHAR_BACKSLASH, 1'b0);
    send_text(CHAR_N, 1'b0);
    send_text(CHAR_QUOTE, 1'b0);
  endtask

  task automatic test_unicode_extremes();
    send_text(CHAR_QUOTE, 1'b0);
    send_unicode(16'h0000, 4);
    send_unicode(16'hffff, 4);
    send_text(CHAR_QUOTE, 1'b0);
  endtask

  task automatic test_abnormal_endings();
    send_text(CHAR_QUOTE, 1'b0);
    send_text(8'($urandom_range(0, 255)), 1'b1);
    send_text(CHAR_QUOTE, 1'b0);
    send_text(CHAR_BACKSLASH, 1'b0);
    send_text(8'($urandom_range(0, 255)), 1'b1);
    send_text(CHAR_QUOTE, 1'b0);
    send_unicode(16'ha000, 1);
    send_text(CHAR_UPPER_F + 8'd1, 1'b0);
  endtask

  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_request = 80;
    send_text(CHAR_QUOTE, 1'b0);
    repeat (12) send_text(8'($urandom_range(93, 126)), 1'b0);
    send_unicode(16'h20ac, 4);
    send_unicode(16'h07ff, 4);
    send_unicode(16'h0800, 4);
    send_text(CHAR_QUOTE, 1'b0);
    sender_idles = 1'b1;
  endtask

  task automatic send_random_string();
    int unsigned pick;
    logic [7:0]  b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_text(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end
      return;
    end
    send_text(8'($urandom_range(0, 255)), 1'b0);
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
        send_text(b, 1'b0);
      end else if (pick < 60) begin
        send_text(CHAR_BACKSLASH, 1'b0);
        send_text(escape_letter($urandom_range(0, 7)), 1'b0);
      end else if (pick < 67) begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH, CHAR_B, CHAR_F, CHAR_N,
                         CHAR_R, CHAR_T, CHAR_U});
        send_text(CHAR_BACKSLASH, 1'b0);
        send_text(b, 1'b0);
      end else if (pick < 95) begin
        send_unicode(random_code_point(), 4);
      end else begin
        send_unicode(random_code_point(), $urandom_range(0, 3));
        send_text(bad_hex_char(), 1'b0);
        return;
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      send_text(CHAR_QUOTE, 1'b0);
    end else if (pick < 88) begin
      send_text(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 94) begin
      send_text(CHAR_BACKSLASH, 1'b0);
      send_text(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_unicode(random_code_point(), $urandom_range(0, 3));
      send_text(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_strings();
    int unsigned first;
    bit          steady;
    first = in_count;
    while (in_count - first < RANDOM_ITEMS) begin
      steady = (in_count - first >= 60) && (in_count - first < 130);
      sender_idles = !steady;
      receiver_idles = !steady;
      send_random_string();
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.text_byte <= 8'h00;
    in_ch.end_of_data <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_framing();
    test_unicode_extremes();
    test_abnormal_endings();
    test_backpressure();
    test_random_strings();
    in_ch.valid <= 1'b0;
    wait_drained();
    $display("Run covered %0d input transactions and %0d results after reset.",
             in_count, out_count);
    $display("Results seen: %0d data bytes, %0d closed strings, %0d aborted strings.",
             data_count, closed_count, abort_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still expected.", decoded_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
